// ----- hw/rtl/cpwm_pkg.sv -----
// shared constants and types for the capture pulse width meter
package cpwm_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int CAP_W  = 16;
    localparam int CFG_W  = 16;
    localparam int US_OUT = 32;

    // op codes of the input beat
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDTHS_WANTED = 1'b0;
    localparam logic CFG_SCALE_Q16     = 1'b1;

    localparam logic [CFG_W-1:0] WIDTHS_WANTED_RST = 16'd1;
    localparam logic [CFG_W-1:0] SCALE_Q16_RST     = 16'd1092;
    localparam logic [CFG_W-1:0] OVF_MAX           = 16'hFFFF;
    localparam logic [CFG_W-1:0] HALF_Q16          = 16'h8000;

    typedef struct packed {
        logic last;
        logic error;
    } t_s1_flags;

endpackage

// ----- hw/rtl/cpwm_in_if.sv -----
// input channel: command, capture or overflow beats
interface cpwm_in_if;
    import cpwm_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0]  op;
    logic [CAP_W-1:0] capture_value;

    modport source (output valid, output op, output capture_value, input ready);
    modport sink   (input valid, input op, input capture_value, output ready);
endinterface

// ----- hw/rtl/cpwm_out_if.sv -----
// output channel: one measured width per beat
interface cpwm_out_if;
    import cpwm_pkg::*;

    logic              valid;
    logic              ready;
    logic [US_OUT-1:0] width_us;
    logic              last;
    logic              error;

    modport source (output valid, output width_us, output last, output error, input ready);
    modport sink   (input valid, input width_us, input last, input error, output ready);
endinterface

// ----- hw/rtl/capture_pulse_width_meter_top.sv -----
// pulse width meter over a free-running input-capture timer
// path: an accepted capture beat goes to the tick count register, then to the
//   scaled width register, which drives the output
// throughput: one input beat per cycle unless o_out stalls, set by the single tick adder and one multiplier
// reset clears run state, the pipeline valids and restores both config registers
module capture_pulse_width_meter_top #(
    parameter int COUNTER_BITS = cpwm_pkg::COUNTER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [cpwm_pkg::CFG_W-1:0] i_cfg_data,
    cpwm_in_if.sink                  i_in,
    cpwm_out_if.source               o_out
);
    import cpwm_pkg::*;

    localparam int CUR_W  = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
    localparam int TICK_W = COUNTER_BITS + CFG_W;
    localparam int Q_W    = TICK_W + CFG_W;
    localparam int SAT_W  = (TICK_W + 1 > US_OUT + 1) ? TICK_W + 1 : US_OUT + 1;
    localparam logic [TICK_W-1:0] SPAN = {{(TICK_W-1){1'b0}}, 1'b1} << COUNTER_BITS;

    // config
    logic [CFG_W-1:0] r_wanted;
    logic [CFG_W-1:0] r_scale;

    // run state
    logic             r_active;
    logic             r_have_ref;
    logic [CUR_W-1:0] r_prev;
    logic [CFG_W-1:0] r_ovf;
    logic [CFG_W-1:0] r_done;

    // stage 1: tick count
    logic              r_s1_valid;
    logic [TICK_W-1:0] r_s1_ticks;
    t_s1_flags         r_s1_flags;

    // stage 2: output register
    logic              r_out_valid;
    logic [US_OUT-1:0] r_out_us;
    t_s1_flags         r_out_flags;

    logic              s1_adv;
    logic              in_acc;
    logic              produce;
    logic [CUR_W-1:0]  cur;
    logic [TICK_W-1:0] cur_x;
    logic [TICK_W-1:0] prev_x;
    logic [TICK_W-1:0] ticks;
    logic              ticks_ok;
    logic [CFG_W-1:0]  n_done;
    logic              fin;

    logic [Q_W-1:0]    q;
    logic [TICK_W-1:0] us;
    logic [SAT_W-1:0]  us_rnd;
    logic [US_OUT-1:0] us_sat;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign cur     = i_in.capture_value[CUR_W-1:0];
    assign cur_x   = TICK_W'(cur);
    assign prev_x  = TICK_W'(r_prev);
    assign produce = (i_in.op == OP_CAPTURE) && r_active && r_have_ref;

    always_comb begin
        if (r_ovf == '0) begin
            if (cur <= r_prev) begin
                ticks = SPAN - prev_x + cur_x;
            end else begin
                ticks = cur_x - prev_x + TICK_W'(1);
            end
        end else begin
            ticks = {r_ovf, {COUNTER_BITS{1'b0}}} - prev_x + cur_x;
        end
    end

    assign ticks_ok = (ticks != '0);
    assign n_done   = r_done + CFG_W'(1);
    assign fin      = (n_done >= r_wanted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= WIDTHS_WANTED_RST;
            r_scale  <= SCALE_Q16_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTHS_WANTED: r_wanted <= i_cfg_data;
                CFG_SCALE_Q16:     r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_have_ref <= 1'b0;
            r_prev     <= '0;
            r_ovf      <= '0;
            r_done     <= '0;
        end else if (in_acc) begin
            if (i_in.op == OP_START) begin
                r_active   <= 1'b1;
                r_have_ref <= 1'b0;
                r_prev     <= '0;
                r_ovf      <= '0;
                r_done     <= '0;
            end else if (r_active && i_in.op == OP_TICK) begin
                if (r_ovf != OVF_MAX) begin
                    r_ovf <= r_ovf + CFG_W'(1);
                end
            end else if (r_active && i_in.op == OP_CAPTURE) begin
                r_have_ref <= 1'b1;
                r_prev     <= cur;
                r_ovf      <= '0;
                if (r_have_ref) begin
                    if (!ticks_ok) begin
                        r_active <= 1'b0;
                    end else begin
                        r_done <= n_done;
                        if (fin) begin
                            r_active <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= in_acc && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && produce) begin
            r_s1_ticks       <= ticks;
            r_s1_flags.error <= !ticks_ok;
            r_s1_flags.last  <= !ticks_ok || fin;
        end
    end

    // scale by q16 factor, round up only above one half, saturate to 32 bits
    assign q      = Q_W'(r_s1_ticks) * Q_W'(r_scale);
    assign us     = q[Q_W-1:CFG_W];
    assign us_rnd = SAT_W'(us) + SAT_W'(q[CFG_W-1:0] > HALF_Q16);
    assign us_sat = (us_rnd[SAT_W-1:US_OUT] != '0) ? {US_OUT{1'b1}} : us_rnd[US_OUT-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_us    <= r_s1_flags.error ? '0 : us_sat;
            r_out_flags <= r_s1_flags;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.width_us = r_out_us;
    assign o_out.last     = r_out_flags.last;
    assign o_out.error    = r_out_flags.error;

    // a beat that gives no width leaves stage 1 empty
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !produce) |=> !r_s1_valid)
        else $error("stage 1 holds a width for a beat that gives none");

    // the final width of a run closes it
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && produce && (fin || !ticks_ok)) |=> !r_active)
        else $error("run still open after its final width");

    // overflow count saturates
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_active && i_in.op == OP_TICK && r_ovf == OVF_MAX) |=> r_ovf == OVF_MAX)
        else $error("overflow count wrapped");

    // an error beat is always the last of its run and carries no width
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> (o_out.last && o_out.width_us == '0))
        else $error("error beat not marked last or has a width");

    // a width reaches the output in the cycle after stage 1 advances
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("width lost between stage 1 and output");

endmodule

// ----- dv/cpwm_checker.sv -----
// scoreboard for the capture pulse width meter: predicts every width beat and compares it
module cpwm_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [cpwm_pkg::CFG_W-1:0] i_cfg_data,
    cpwm_in_if                         i_in_ch,
    cpwm_out_if                        i_out_ch,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpwm_pkg::*;

    typedef struct packed {
        logic [US_OUT-1:0] width_us;
        logic              last;
        logic              error;
    } t_width_beat;

    // one full turn of the capture counter
    localparam logic [63:0] SPAN = 64'd1 << COUNTER_BITS_DEF;

    logic [CFG_W-1:0] wanted_r;
    logic [CFG_W-1:0] scale_r;
    logic             run_on;
    logic             ref_seen;
    logic [CAP_W-1:0] prev_cap;
    logic [CFG_W-1:0] ovf_cnt;
    logic [CFG_W-1:0] done_cnt;
    t_width_beat      widths_due[$];

    // ticks times the Q0.16 factor, rounded up only above one half, saturated to 32 bits
    function automatic logic [US_OUT-1:0] ticks_to_us(input logic [63:0] ticks,
                                                     input logic [CFG_W-1:0] scale);
        logic [63:0] prod;
        logic [63:0] us;
        prod = ticks * 64'(scale);
        us   = prod >> 16;
        if (prod[15:0] > HALF_Q16) begin
            us = us + 64'd1;
        end
        if (us > 64'hFFFF_FFFF) begin
            us = 64'hFFFF_FFFF;
        end
        return us[US_OUT-1:0];
    endfunction

    task automatic predict_beat(input logic [OP_W-1:0] op, input logic [CAP_W-1:0] cap);
        logic [63:0] cur;
        logic [63:0] ticks;
        t_width_beat w;
        cur = 64'(cap) & (SPAN - 64'd1);
        if (op == OP_START) begin
            run_on   = 1'b1;
            ref_seen = 1'b0;
            prev_cap = '0;
            ovf_cnt  = '0;
            done_cnt = '0;
        end else if (run_on && op == OP_TICK) begin
            if (ovf_cnt != OVF_MAX) begin
                ovf_cnt++;
            end
        end else if (run_on && op == OP_CAPTURE) begin
            if (!ref_seen) begin
                // reference edge drops any overflow seen before it
                ref_seen = 1'b1;
                prev_cap = CAP_W'(cur);
                ovf_cnt  = '0;
            end else begin
                if (ovf_cnt == 0) begin
                    if (cur <= 64'(prev_cap)) begin
                        ticks = SPAN - 64'(prev_cap) + cur;
                    end else begin
                        ticks = cur - 64'(prev_cap) + 64'd1;
                    end
                end else begin
                    ticks = SPAN * 64'(ovf_cnt) - 64'(prev_cap) + cur;
                end
                prev_cap = CAP_W'(cur);
                ovf_cnt  = '0;
                if (ticks == 0) begin
                    run_on     = 1'b0;
                    w.width_us = '0;
                    w.last     = 1'b1;
                    w.error    = 1'b1;
                end else begin
                    done_cnt++;
                    w.width_us = ticks_to_us(ticks, scale_r);
                    w.last     = (done_cnt >= wanted_r);
                    w.error    = 1'b0;
                    if (w.last) begin
                        run_on = 1'b0;
                    end
                end
                widths_due.push_back(w);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_width_beat want;
        if (!i_rst_n) begin
            wanted_r = WIDTHS_WANTED_RST;
            scale_r  = SCALE_Q16_RST;
            run_on   = 1'b0;
            ref_seen = 1'b0;
            prev_cap = '0;
            ovf_cnt  = '0;
            done_cnt = '0;
            widths_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTHS_WANTED) begin
                    wanted_r = i_cfg_data;
                end else begin
                    scale_r = i_cfg_data;
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_beat(i_in_ch.op, i_in_ch.capture_value);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (widths_due.size() == 0) begin
                    $error("unexpected width beat: width_us %0d last %0b error %0b",
                           i_out_ch.width_us, i_out_ch.last, i_out_ch.error);
                    o_fail_count++;
                end else begin
                    want = widths_due.pop_front();
                    if (i_out_ch.width_us !== want.width_us) begin
                        $error("width_us: expected %0d, got %0d", want.width_us,
                               i_out_ch.width_us);
                        o_fail_count++;
                    end
                    if (i_out_ch.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out_ch.last);
                        o_fail_count++;
                    end
                    if (i_out_ch.error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, i_out_ch.error);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = widths_due.size();
    end

endmodule

// ----- dv/tb_capture_pulse_width_meter_top.sv -----
// testbench top for the capture pulse width meter: clock, reset, stimulus and verdict
module tb_capture_pulse_width_meter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpwm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int OVF_BURST    = 24;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               widths_pending;
    int               cycle_cnt;
    int               beats_sent;
    bit               calm;
    logic [CFG_W-1:0] run_len;

    cpwm_in_if  in_ch ();
    cpwm_out_if out_ch ();

    capture_pulse_width_meter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    cpwm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (widths_pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("capture_pulse_width_meter_top: mismatch");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OP_W-1:0] noise_op();
        case ($urandom_range(0, 3))
            0: begin
                return OP_START;
            end
            1: begin
                return OP_CAPTURE;
            end
            2: begin
                return OP_TICK;
            end
            default: begin
                return OP_SPARE;
            end
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] next_capture(input logic [CAP_W-1:0] prev);
        case ($urandom_range(0, 7))
            0: begin
                return prev;
            end
            1: begin
                return prev + 1'b1;
            end
            2: begin
                return prev - 1'b1;
            end
            3: begin
                return '0;
            end
            4: begin
                return '1;
            end
            default: begin
                return CAP_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_wanted();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return 16'd65534;
            end
            2: begin
                return '1;
            end
            3: begin
                return CFG_W'($urandom);
            end
            default: begin
                return CFG_W'($urandom_range(1, 6));
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return 16'd1;
            end
            2: begin
                return '1;
            end
            3: begin
                return SCALE_Q16_RST;
            end
            4: begin
                return HALF_Q16;
            end
            5: begin
                return HALF_Q16 + 1'b1;
            end
            default: begin
                return CFG_W'($urandom);
            end
        endcase
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back beats
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [CAP_W-1:0] cap);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= op;
        in_ch.capture_value <= cap;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (widths_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] wanted, input logic [CFG_W-1:0] scale);
        drain();
        cfg_write(CFG_WIDTHS_WANTED, wanted);
        cfg_write(CFG_SCALE_Q16, scale);
        run_len = wanted;
    endtask

    task automatic random_run();
        int n_widths;
        logic [CAP_W-1:0] cap;
        send_beat(OP_START, CAP_W'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            // broken run: anything goes
            repeat ($urandom_range(1, 6)) send_beat(noise_op(), CAP_W'($urandom));
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(OP_TICK, CAP_W'($urandom));
        end
        cap = CAP_W'($urandom);
        send_beat(OP_CAPTURE, cap);
        // long runs get cut short by the next start
        if (run_len == 0) begin
            n_widths = 1;
        end else if (run_len > 8) begin
            n_widths = $urandom_range(1, 8);
        end else begin
            n_widths = run_len;
        end
        repeat (n_widths) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 2)) send_beat(OP_TICK, CAP_W'($urandom));
                end
                5, 6: begin
                    repeat ($urandom_range(3, 20)) send_beat(OP_TICK, CAP_W'($urandom));
                end
                default: begin
                end
            endcase
            cap = next_capture(cap);
            send_beat(OP_CAPTURE, cap);
        end
        if ($urandom_range(0, 4) == 0) begin
            send_beat(noise_op(), CAP_W'($urandom));
        end
    endtask

    // result side: random stalls of random length, none while calm
    initial begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_WIDTHS_WANTED;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_START;
        in_ch.capture_value = '0;
        calm                = 1'b0;
        run_len             = WIDTHS_WANTED_RST;
        beats_sent          = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one width per run, equal captures give a full turn
        send_beat(OP_START, 16'h0000);
        send_beat(OP_CAPTURE, 16'h1234);
        send_beat(OP_CAPTURE, 16'h1234);
        send_beat(OP_CAPTURE, 16'hFFFF);
        send_beat(OP_TICK, 16'hFFFF);
        send_beat(OP_SPARE, 16'hA5A5);

        // fraction of exactly one half stays down
        load_config(16'd4, HALF_Q16);
        send_beat(OP_START, 16'hFFFF);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_CAPTURE, 16'hFFFF);
        send_beat(OP_CAPTURE, 16'h0000);
        send_beat(OP_SPARE, 16'h5A5A);
        send_beat(OP_CAPTURE, 16'h0001);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_CAPTURE, 16'h0000);
        send_beat(OP_START, 16'h0000);
        send_beat(OP_CAPTURE, 16'd100);
        repeat (3) send_beat(OP_TICK, 16'h0000);
        send_beat(OP_CAPTURE, 16'hFFFF);

        // just above one half rounds up
        load_config(16'd1, HALF_Q16 + 1'b1);
        send_beat(OP_START, 16'h0000);
        send_beat(OP_CAPTURE, 16'hFFFF);
        send_beat(OP_CAPTURE, 16'h0000);

        // a long burst of overflows at full scale
        load_config(16'd2, '1);
        calm = 1'b1;
        send_beat(OP_START, 16'h0000);
        send_beat(OP_CAPTURE, 16'h0000);
        repeat (OVF_BURST) send_beat(OP_TICK, CAP_W'($urandom));
        send_beat(OP_CAPTURE, 16'hFFFF);
        send_beat(OP_CAPTURE, 16'hFFFF);
        calm = 1'b0;

        while (beats_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            load_config(pick_wanted(), pick_scale());
            repeat ($urandom_range(3, 8)) begin
                if (beats_sent < RANDOM_ITEMS) begin
                    random_run();
                end
            end
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("capture_pulse_width_meter_top: match");
        end else begin
            $display("capture_pulse_width_meter_top: mismatch");
        end
        $finish;
    end

endmodule
